// File: design/source_text_tokenizer_assert.svh
// Assertion macros for the source text tokenizer.
// Used by design/source_text_tokenizer.sv; expects clk and arst_n in scope.
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STT_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/stt_pkg.sv
// Shared types, constants and character helpers of the source text tokenizer.
// No dependencies; used by design/source_text_tokenizer.sv.
`default_nettype none

package stt_pkg;

	// Longest token length that is counted; longer tokens saturate.
	localparam int MAX_TOKEN_LENGTH = 255;
	localparam logic [7:0] LEN_CAP = 8'((MAX_TOKEN_LENGTH < 255) ? MAX_TOKEN_LENGTH : 255);

	// Lengths of the two keywords.
	localparam logic [7:0] KW_RETURN_LEN = 8'd6;
	localparam logic [7:0] KW_INT_LEN    = 8'd3;

	// Scanner modes between characters.
	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_NUM   = 3'd1,
		MODE_ID    = 3'd2,
		MODE_SLASH = 3'd3,
		MODE_STAR  = 3'd4,
		MODE_DOT   = 3'd5
	} mode_t;

	// Token kinds as they appear on the result channel.
	typedef enum logic [3:0] {
		KIND_EOF     = 4'd0,
		KIND_DSLASH  = 4'd1,
		KIND_COPEN   = 4'd2,
		KIND_CCLOSE  = 4'd3,
		KIND_PERIOD  = 4'd4,
		KIND_INT     = 4'd5,
		KIND_FLOAT   = 4'd6,
		KIND_ID      = 4'd7,
		KIND_RETURN  = 4'd8,
		KIND_TYPE    = 4'd9,
		KIND_UNKNOWN = 4'd10
	} kind_t;

	// One result as held in the output queue.
	typedef struct packed {
		kind_t       kind;
		logic [31:0] start;
		logic [7:0]  length;
		logic [7:0]  first;
		logic        last;
	} token_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha_us(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
	endfunction

	// Character of 'return' at a given place.
	function automatic logic [7:0] kw_return_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = "r";
			3'd1: c = "e";
			3'd2: c = "t";
			3'd3: c = "u";
			3'd4: c = "r";
			3'd5: c = "n";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Character of 'int' at a given place.
	function automatic logic [7:0] kw_int_char(input logic [1:0] idx);
		logic [7:0] c;
		unique case (idx)
			2'd0: c = "i";
			2'd1: c = "n";
			2'd2: c = "t";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// File: design/source_text_tokenizer.sv
// Source text tokenizer: one character per request in, tokens out with kind,
// start offset, saturated length and first character. A request with is_end
// high flushes the pending token and then gives an end-of-file token. Each
// request goes through one input register and the scanner logic into a
// two-entry result queue, so a character is taken every cycle unless the
// queue lacks room, and its tokens reach the result ports from the queue. A
// character that closes one token and is itself a one-character token, or an
// end mark that closes a pending token, yields two results; such a request
// waits in the input register until the queue will be empty, which stalls
// input even when the queue is full and draining.
// There is no clearing pass after reset.
// Depends on design/stt_pkg.sv and design/source_text_tokenizer_assert.svh.
`default_nettype none

`include "source_text_tokenizer_assert.svh"

module source_text_tokenizer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [7:0]  ch,
	input  wire logic        is_end,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [3:0]  token_kind,
	output      logic [31:0] token_start,
	output      logic [7:0]  token_length,
	output      logic [7:0]  first_char,
	output      logic        last
);

	// Input register.
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       is_end_s1;

	// Scanner state.
	stt_pkg::mode_t mode_q, mode_d;
	logic [7:0]     len_q, len_d;
	logic [31:0]    start_q, start_d;
	logic [31:0]    pos_q, pos_d;
	logic [1:0]     dots_q, dots_d;
	logic [1:0]     kw_q, kw_d;
	logic [7:0]     open_q, open_d;

	// Scanner results for the item in the input register.
	stt_pkg::token_t res0, res1, flush_tok;
	logic [1:0]      nres;
	logic [7:0]      len_inc;
	logic            do_flush;
	logic            do_start;

	// Result queue.
	stt_pkg::token_t q0_q, q1_q, q0_d, q1_d;
	logic [1:0]      cnt_q, cnt_d;
	logic            pop;
	logic [1:0]      base;
	logic            room;
	logic            adv_s1;

	// Handshake and queue occupancy.
	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && !out_stall;
	assign base      = cnt_q - {1'b0, pop};
	assign room      = ({1'b0, base} + {1'b0, nres}) <= 3'd2;
	assign adv_s1    = valid_s1 && room;
	assign in_stall  = valid_s1 && !adv_s1;

	// Input register: valid flag is reset, the payload is not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ch_s1     <= ch;
			is_end_s1 <= is_end;
		end
	end

	// Token held in the state, as given out when it is closed.
	always_comb begin
		flush_tok        = '0;
		flush_tok.start  = start_q;
		flush_tok.length = len_q;
		flush_tok.first  = open_q;
		unique case (mode_q)
			stt_pkg::MODE_NUM: begin
				if (dots_q == 2'd0) begin
					flush_tok.kind = stt_pkg::KIND_INT;
				end else if (dots_q == 2'd1) begin
					flush_tok.kind = stt_pkg::KIND_FLOAT;
				end else begin
					flush_tok.kind = stt_pkg::KIND_UNKNOWN;
				end
			end
			stt_pkg::MODE_ID: begin
				if (len_q == stt_pkg::KW_RETURN_LEN && kw_q[0]) begin
					flush_tok.kind = stt_pkg::KIND_RETURN;
				end else if (len_q == stt_pkg::KW_INT_LEN && kw_q[1]) begin
					flush_tok.kind = stt_pkg::KIND_TYPE;
				end else begin
					flush_tok.kind = stt_pkg::KIND_ID;
				end
			end
			stt_pkg::MODE_DOT: flush_tok.kind = stt_pkg::KIND_PERIOD;
			default: flush_tok.kind = stt_pkg::KIND_UNKNOWN;
		endcase
	end

	assign len_inc = (len_q < stt_pkg::LEN_CAP) ? len_q + 8'd1 : len_q;

	// Scanner step: next state and up to two results for one character.
	always_comb begin
		mode_d   = mode_q;
		len_d    = len_q;
		start_d  = start_q;
		pos_d    = pos_q;
		dots_d   = dots_q;
		kw_d     = kw_q;
		open_d   = open_q;
		res0     = '0;
		res1     = '0;
		nres     = 2'd0;
		do_flush = 1'b0;
		do_start = 1'b0;

		if (is_end_s1) begin
			// End of file: close any pending token, then the end token.
			if (mode_q != stt_pkg::MODE_IDLE) begin
				res0       = flush_tok;
				res1.kind  = stt_pkg::KIND_EOF;
				res1.start = pos_q;
				nres       = 2'd2;
				mode_d     = stt_pkg::MODE_IDLE;
				kw_d       = 2'b11;
			end else begin
				res0.kind  = stt_pkg::KIND_EOF;
				res0.start = pos_q;
				nres       = 2'd1;
			end
		end else begin
			pos_d = pos_q + 32'd1;
			unique case (mode_q)
				stt_pkg::MODE_NUM: begin
					if (stt_pkg::is_digit(ch_s1) || ch_s1 == ".") begin
						len_d = len_inc;
						if (ch_s1 == "." && dots_q < 2'd2) begin
							dots_d = dots_q + 2'd1;
						end
					end else begin
						do_flush = 1'b1;
						do_start = 1'b1;
					end
				end
				stt_pkg::MODE_ID: begin
					if (stt_pkg::is_alpha_us(ch_s1) || stt_pkg::is_digit(ch_s1)) begin
						kw_d[0] = kw_q[0] && (len_q < stt_pkg::KW_RETURN_LEN)
							&& (ch_s1 == stt_pkg::kw_return_char(len_q[2:0]));
						kw_d[1] = kw_q[1] && (len_q < stt_pkg::KW_INT_LEN)
							&& (ch_s1 == stt_pkg::kw_int_char(len_q[1:0]));
						len_d = len_inc;
					end else begin
						do_flush = 1'b1;
						do_start = 1'b1;
					end
				end
				stt_pkg::MODE_SLASH: begin
					if (ch_s1 == "/" || ch_s1 == "*") begin
						if (ch_s1 == "/") begin
							res0.kind = stt_pkg::KIND_DSLASH;
						end else begin
							res0.kind = stt_pkg::KIND_COPEN;
						end
						res0.start  = start_q;
						res0.length = 8'd2;
						res0.first  = "/";
						nres        = 2'd1;
						mode_d      = stt_pkg::MODE_IDLE;
					end else begin
						do_flush = 1'b1;
						do_start = 1'b1;
					end
				end
				stt_pkg::MODE_STAR: begin
					if (ch_s1 == "/") begin
						res0.kind   = stt_pkg::KIND_CCLOSE;
						res0.start  = start_q;
						res0.length = 8'd2;
						res0.first  = "*";
						nres        = 2'd1;
						mode_d      = stt_pkg::MODE_IDLE;
					end else begin
						do_flush = 1'b1;
						do_start = 1'b1;
					end
				end
				stt_pkg::MODE_DOT: begin
					if (stt_pkg::is_digit(ch_s1)) begin
						mode_d = stt_pkg::MODE_NUM;
						len_d  = len_inc;
						dots_d = 2'd1;
					end else begin
						do_flush = 1'b1;
						do_start = 1'b1;
					end
				end
				default: begin
					mode_d   = stt_pkg::MODE_IDLE;
					do_start = 1'b1;
				end
			endcase

			// A character that ends a token closes it first.
			if (do_flush) begin
				res0   = flush_tok;
				nres   = 2'd1;
				mode_d = stt_pkg::MODE_IDLE;
				kw_d   = 2'b11;
			end

			// The character then opens a new token, or is a token by itself.
			if (do_start && !(ch_s1 == " " || ch_s1 == "\n")) begin
				priority if (ch_s1 == "/" || ch_s1 == "*" || ch_s1 == "."
					|| stt_pkg::is_digit(ch_s1) || stt_pkg::is_alpha_us(ch_s1)) begin
					start_d = pos_q;
					len_d   = 8'd1;
					open_d  = ch_s1;
					dots_d  = 2'd0;
					kw_d    = 2'b11;
					priority if (ch_s1 == "/") begin
						mode_d = stt_pkg::MODE_SLASH;
					end else if (ch_s1 == "*") begin
						mode_d = stt_pkg::MODE_STAR;
					end else if (ch_s1 == ".") begin
						mode_d = stt_pkg::MODE_DOT;
					end else if (stt_pkg::is_digit(ch_s1)) begin
						mode_d = stt_pkg::MODE_NUM;
					end else begin
						mode_d = stt_pkg::MODE_ID;
						kw_d   = {ch_s1 == "i", ch_s1 == "r"};
					end
				end else if (do_flush) begin
					res1.kind   = stt_pkg::KIND_UNKNOWN;
					res1.start  = pos_q;
					res1.length = 8'd1;
					res1.first  = ch_s1;
					nres        = 2'd2;
				end else begin
					res0.kind   = stt_pkg::KIND_UNKNOWN;
					res0.start  = pos_q;
					res0.length = 8'd1;
					res0.first  = ch_s1;
					nres        = 2'd1;
				end
			end
		end

		// Mark the final result of this request.
		if (nres == 2'd2) begin
			res1.last = 1'b1;
		end else if (nres == 2'd1) begin
			res0.last = 1'b1;
		end
	end

	// Scanner state register, updated as the input register's item is consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= stt_pkg::MODE_IDLE;
			len_q   <= 8'd0;
			start_q <= 32'd0;
			pos_q   <= 32'd0;
			dots_q  <= 2'd0;
			kw_q    <= 2'b11;
			open_q  <= 8'd0;
		end else if (adv_s1) begin
			mode_q  <= mode_d;
			len_q   <= len_d;
			start_q <= start_d;
			pos_q   <= pos_d;
			dots_q  <= dots_d;
			kw_q    <= kw_d;
			open_q  <= open_d;
		end
	end

	// Result queue: shift on a pop, append new results after what remains.
	always_comb begin
		q0_d  = pop ? q1_q : q0_q;
		q1_d  = q1_q;
		cnt_d = base;
		if (adv_s1 && nres != 2'd0) begin
			cnt_d = base + nres;
			if (base == 2'd0) begin
				q0_d = res0;
				q1_d = res1;
			end else begin
				q1_d = res0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		q0_q <= q0_d;
		q1_q <= q1_d;
	end

	assign token_kind   = q0_q.kind;
	assign token_start  = q0_q.start;
	assign token_length = q0_q.length;
	assign first_char   = q0_q.first;
	assign last         = q0_q.last;

	// Checks on the queue and the scanner.
	`STT_ASSERT_IMPLY(a_cnt_range, 1'b1, cnt_q != 2'd3, "result queue over-full")
	`STT_ASSERT_IMPLY(a_two_into_empty, adv_s1 && nres == 2'd2, base == 2'd0,
		"two results pushed into a non-empty queue")
	`STT_ASSERT_NEXT(a_held_result, out_valid && out_stall, out_valid,
		"stalled result lost from queue")
	`STT_ASSERT_IMPLY(a_eof_last, out_valid && token_kind == stt_pkg::KIND_EOF, last,
		"end-of-file token not marked last")

endmodule

`default_nettype wire
